// File: src/rsd_pkg.sv
package rsd_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int IDX_W = $clog2(MAX_RECORDS);
  localparam int CNT_W = IDX_W + 1;

  typedef struct packed {
    logic [15:0] date_hi;
    logic [63:0] date_lo;
    logic [39:0] time_text;
    logic [31:0] step_count;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_EMIT,
    ST_EMIT_RD,
    ST_EMIT_HOLD
  } state_e;

endpackage

// File: src/record_sorter_descending.sv
// Descending record sorter.
// Input channel: in_valid_i / in_stall_o with one record per transfer; last_i
// closes a batch. Output channel: out_valid_o / out_stall_i, one record per
// transfer, in descending order of step count, equal counts in arrival order.
// Records are held in one synchronous store of MAX_RECORDS entries, kept
// sorted. A record is inserted by walking down from the top entry, one
// read and one write-back per cycle, moving smaller entries up by one.
// An empty store is written directly, and a record arriving at a full store
// is dropped without a walk. The store's single read port makes the walk
// visit one entry at a time.
// When the last record has been inserted, the batch is read out one result
// at a time through ST_EMIT, ST_EMIT_RD and ST_EMIT_HOLD; a stalled result
// holds and no input is taken until the batch has gone.
// Records arriving at a full store are dropped and every result of that
// batch carries overflowed_o. An empty batch gives no results.
// Reset empties the store and clears the overflow flag; no clearing pass
// is needed.
module record_sorter_descending (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] date_hi_i,
  input  logic [63:0] date_lo_i,
  input  logic [39:0] time_text_i,
  input  logic signed [31:0] step_count_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_date_hi_o,
  output logic [63:0] out_date_lo_o,
  output logic [39:0] out_time_text_o,
  output logic signed [31:0] out_step_count_o,
  output logic        out_last_o,
  output logic        overflowed_o
);
  import rsd_pkg::*;

  rec_t store_q [MAX_RECORDS];
  rec_t rd_q;
  rec_t rec_q, rec_d;
  rec_t out_q, out_d;
  logic last_q, last_d;
  logic ovf_q, ovf_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic out_valid_q, out_valid_d;
  logic out_last_q, out_last_d;
  logic out_ovf_q, out_ovf_d;
  state_e state_q, state_d;

  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic we;
  rec_t wr_data;
  rec_t in_rec;
  logic accept;

  assign in_rec = '{date_hi: date_hi_i, date_lo: date_lo_i,
                    time_text: time_text_i, step_count: step_count_i};
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[wr_addr] <= wr_data;
    end
    rd_q <= store_q[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    rec_d = rec_q;
    last_d = last_q;
    ovf_d = ovf_q;
    fill_d = fill_q;
    idx_d = idx_q;
    out_d = out_q;
    out_valid_d = out_valid_q;
    out_last_d = out_last_q;
    out_ovf_d = out_ovf_q;
    rd_addr = idx_q[IDX_W-1:0];
    wr_addr = '0;
    wr_data = rec_q;
    we = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rec_d = in_rec;
          last_d = last_i;
          if (fill_q == CNT_W'(MAX_RECORDS)) begin
            ovf_d = 1'b1;
            if (last_i) begin
              idx_d = '0;
              state_d = ST_EMIT;
            end
          end else if (fill_q == '0) begin
            we = 1'b1;
            wr_addr = '0;
            wr_data = in_rec;
            fill_d = CNT_W'(1);
            if (last_i) begin
              idx_d = '0;
              state_d = ST_EMIT;
            end
          end else begin
            idx_d = fill_q - CNT_W'(1);
            rd_addr = idx_d[IDX_W-1:0];
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        we = 1'b1;
        wr_addr = IDX_W'(idx_q + CNT_W'(1));
        if ($signed(rd_q.step_count) < $signed(rec_q.step_count)) begin
          // The stored record is smaller: it moves up one place.
          wr_data = rd_q;
          if (idx_q == '0) begin
            state_d = ST_PLACE;
          end else begin
            idx_d = idx_q - CNT_W'(1);
            rd_addr = idx_d[IDX_W-1:0];
          end
        end else begin
          wr_data = rec_q;
          fill_d = fill_q + CNT_W'(1);
          idx_d = '0;
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_PLACE: begin
        we = 1'b1;
        wr_addr = '0;
        wr_data = rec_q;
        fill_d = fill_q + CNT_W'(1);
        idx_d = '0;
        state_d = last_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (idx_q == fill_q) begin
          fill_d = '0;
          ovf_d = 1'b0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        out_d = rd_q;
        out_valid_d = 1'b1;
        out_last_d = (idx_q + CNT_W'(1)) == fill_q;
        out_ovf_d = ovf_q;
        idx_d = idx_q + CNT_W'(1);
        state_d = ST_EMIT_HOLD;
      end
      ST_EMIT_HOLD: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          state_d = ST_EMIT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q <= '0;
      ovf_q <= 1'b0;
      idx_q <= '0;
      out_valid_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      ovf_q <= ovf_d;
      idx_q <= idx_d;
      out_valid_q <= out_valid_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    out_q <= out_d;
    out_last_q <= out_last_d;
    out_ovf_q <= out_ovf_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_date_hi_o = out_q.date_hi;
  assign out_date_lo_o = out_q.date_lo;
  assign out_time_text_o = out_q.time_text;
  assign out_step_count_o = out_q.step_count;
  assign out_last_o = out_last_q;
  assign overflowed_o = out_ovf_q;

endmodule

// File: src/rsd_checker.sv
module rsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] out_step_count_o,
  input logic        out_last_o
);

  // A result waiting for transfer stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_step_count_o))
    else $error("stalled result changed");

  // No input is taken while a batch is being read out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open during readout");

  // The final result of a batch is followed by a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_last_o |=> !out_valid_o)
    else $error("result after end of batch");

endmodule

bind record_sorter_descending rsd_checker u_rsd_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_step_count_o(out_step_count_o),
  .out_last_o(out_last_o)
);
